// ===== hdl/tpts_pkg.sv =====
// Shared types, sizes and helpers for the timed priority task scheduler.
// Used by the scheduler and the port checker; depends on nothing.
package tpts_pkg;

  localparam int TASK_SLOTS      = 16;
  localparam int PRIORITY_LEVELS = 4;

  // Pointer width holds every slot plus the null value
  localparam int SLOT_W = $clog2(TASK_SLOTS + 1);
  localparam int SIDX_W = $clog2(TASK_SLOTS);
  localparam int PIDX_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [SLOT_W-1:0] NIL = SLOT_W'(TASK_SLOTS);

  typedef enum logic [1:0] {
    CMD_CREATE   = 2'd0,
    CMD_DESTROY  = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_COMPLETE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOHANDLER = 3'd2,
    ST_BADPRIO   = 3'd3,
    ST_BADSLOT   = 3'd4,
    ST_NOTHING   = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  task_slot;
    logic [31:0] handler_tag;
    logic [31:0] event_word;
    logic [31:0] argument_tag;
    logic [31:0] interval_ticks;
    logic        repeat_flag;
    logic [1:0]  priority_level;
    logic [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_slot;
    logic [31:0] out_handler;
    logic [31:0] out_event;
    logic [31:0] out_argument;
  } out_item_t;

  // One task table entry
  typedef struct packed {
    logic [31:0] handler;
    logic [31:0] evt;
    logic [31:0] argument;
    logic [31:0] interval;
    logic [31:0] last_end;
    logic        rpt;
    logic [1:0]  prio;
  } rec_t;

  // a strictly earlier than b, with wrap
  function automatic logic tick_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic prio_bad(input logic [1:0] p);
    return 5'(p) >= 5'(PRIORITY_LEVELS);
  endfunction

  function automatic logic [PIDX_W-1:0] prio_idx(input logic [1:0] p);
    return PIDX_W'(p);
  endfunction

  function automatic logic slot_bad(input logic [3:0] s);
    return 7'(s) >= 7'(TASK_SLOTS);
  endfunction

endpackage

// ===== hdl/tpts_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package needed.
module tpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/timed_priority_task_scheduler.sv =====
// Timed priority task scheduler: one command item in, one result item out.
// Create rebuilds the free chain first when the table is empty; destroy frees
// the running task directly, else searches its ready queue and then the wait
// list; dispatch returns the running task or pops the most urgent ready queue;
// complete frees a one-shot task and puts a repeating one back into the wait
// list sorted by due tick; complete and a dispatch that finds nothing ready then
// promote due wait entries. A stalled output holds the result until it is taken.
// One item at a time; the link and task RAM read ports set the step rate.
// Synchronous active-low reset empties all queues; the RAMs need no clearing.
module timed_priority_task_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpts_pkg::out_item_t out_data
);
  import tpts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_REBUILD, S_C_RD, S_C_USE, S_PUSH1, S_PUSH2,
    S_D_RD, S_D_PRIO, S_U_STEP, S_U_ADV, S_FREE, S_Q_RD, S_Q_TAKE,
    S_X_RD, S_X_UPD, S_W_STEP, S_W_SUM, S_W_CMP, S_W_LINK, S_W_PREV,
    S_P_STEP, S_P_SUM, S_P_CMP, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  out_item_t          res_r, res_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TASK_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [SLOT_W-1:0]  rhead_r [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]  rhead_nxt [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]  rtail_r [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]  rtail_nxt [PRIORITY_LEVELS];
  logic [SLOT_W-1:0]  whead_r, whead_nxt;
  logic [SLOT_W-1:0]  fhead_r, fhead_nxt;
  logic [SLOT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]  run_r, run_nxt;
  logic [SLOT_W-1:0]  s_r, s_nxt;
  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic [SLOT_W-1:0]  prev_r, prev_nxt;
  logic [SLOT_W-1:0]  nx_r, nx_nxt;
  logic [SLOT_W-1:0]  n_r, n_nxt;
  logic [PIDX_W-1:0]  pp_r, pp_nxt;
  logic [31:0]        nr_r, nr_nxt;
  logic [31:0]        t_r, t_nxt;
  logic               inwait_r, inwait_nxt;
  logic               prom_r, prom_nxt;

  logic               lk_we;
  logic [SIDX_W-1:0]  lk_waddr, lk_raddr;
  logic [SLOT_W-1:0]  lk_wdata, lk_rdata;
  logic               rc_we;
  logic [SIDX_W-1:0]  rc_waddr, rc_raddr;
  rec_t               rc_wdata, rc_rdata;

  tpts_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  tpts_ram #(.WIDTH($bits(rec_t)), .DEPTH(TASK_SLOTS)) u_task_ram (
    .clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
    .raddr(rc_raddr), .rdata(rc_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Command sequencer
  always_comb begin
    logic             found;
    logic [PIDX_W-1:0] fp;
    rec_t             nrec;
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_use_nxt    = in_use_r;
    rhead_nxt     = rhead_r;
    rtail_nxt     = rtail_r;
    whead_nxt     = whead_r;
    fhead_nxt     = fhead_r;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    s_nxt         = s_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    nx_nxt        = nx_r;
    n_nxt         = n_r;
    pp_nxt        = pp_r;
    nr_nxt        = nr_r;
    t_nxt         = t_r;
    inwait_nxt    = inwait_r;
    prom_nxt      = prom_r;
    lk_we         = 1'b0;
    lk_waddr      = cur_r[SIDX_W-1:0];
    lk_wdata      = NIL;
    lk_raddr      = cur_r[SIDX_W-1:0];
    rc_we         = 1'b0;
    rc_waddr      = s_r[SIDX_W-1:0];
    rc_wdata      = rc_rdata;
    rc_raddr      = s_r[SIDX_W-1:0];
    found         = 1'b0;
    fp            = '0;
    nrec          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (item_r.command)
          CMD_CREATE: begin
            if (cnt_r >= NIL) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_DONE;
            end else if (item_r.handler_tag == 32'd0) begin
              res_nxt.status = ST_NOHANDLER;
              state_nxt = S_DONE;
            end else if (prio_bad(item_r.priority_level)) begin
              res_nxt.status = ST_BADPRIO;
              state_nxt = S_DONE;
            end else if (cnt_r == '0) begin
              cur_nxt   = '0;
              state_nxt = S_REBUILD;
            end else begin
              state_nxt = S_C_RD;
            end
          end
          CMD_DESTROY: begin
            if (slot_bad(item_r.task_slot) ||
                !in_use_r[SIDX_W'(item_r.task_slot)]) begin
              res_nxt.status = ST_BADSLOT;
              state_nxt = S_DONE;
            end else begin
              s_nxt = SLOT_W'(item_r.task_slot);
              res_nxt.result_slot = item_r.task_slot;
              if (run_r == SLOT_W'(item_r.task_slot)) begin
                run_nxt   = NIL;
                state_nxt = S_FREE;
              end else begin
                state_nxt = S_D_RD;
              end
            end
          end
          CMD_DISPATCH: begin
            if (run_r < NIL) begin
              s_nxt     = run_r;
              state_nxt = S_Q_RD;
            end else begin
              // pick the most urgent non-empty queue
              for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
                if (rhead_r[p] < NIL) begin
                  found = 1'b1;
                  fp    = PIDX_W'(p);
                end
              end
              if (found) begin
                s_nxt     = rhead_r[fp];
                pp_nxt    = fp;
                state_nxt = S_Q_RD;
              end else begin
                res_nxt.status = ST_NOTHING;
                n_nxt     = '0;
                state_nxt = S_P_STEP;
              end
            end
          end
          default: begin
            run_nxt = NIL;
            if (run_r >= NIL || !in_use_r[run_r[SIDX_W-1:0]]) begin
              res_nxt.status = ST_BADSLOT;
              n_nxt     = '0;
              state_nxt = S_P_STEP;
            end else begin
              s_nxt = run_r;
              res_nxt.result_slot = 4'(run_r);
              state_nxt = S_X_RD;
            end
          end
        endcase
      end

      // Lay the free chain out in ascending order
      S_REBUILD: begin
        lk_we    = 1'b1;
        lk_waddr = cur_r[SIDX_W-1:0];
        lk_wdata = cur_r + 1'b1;
        if (cur_r == NIL - 1'b1) begin
          fhead_nxt = '0;
          state_nxt = S_C_RD;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end

      S_C_RD: begin
        if (fhead_r >= NIL) begin
          res_nxt.status = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          s_nxt     = fhead_r;
          lk_raddr  = fhead_r[SIDX_W-1:0];
          state_nxt = S_C_USE;
        end
      end

      // Take the slot off the free list and fill it
      S_C_USE: begin
        fhead_nxt     = lk_rdata;
        nrec.handler  = item_r.handler_tag;
        nrec.evt      = item_r.event_word;
        nrec.argument = item_r.argument_tag;
        nrec.interval = item_r.interval_ticks;
        nrec.last_end = 32'd0;
        nrec.rpt      = item_r.repeat_flag;
        nrec.prio     = item_r.priority_level;
        rc_we         = 1'b1;
        rc_waddr      = s_r[SIDX_W-1:0];
        rc_wdata      = nrec;
        in_use_nxt[s_r[SIDX_W-1:0]] = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        pp_nxt        = prio_idx(item_r.priority_level);
        res_nxt.result_slot = 4'(s_r);
        prom_nxt      = 1'b0;
        state_nxt     = S_PUSH1;
      end

      // Append s_r to the tail of ready queue pp_r
      S_PUSH1: begin
        lk_we     = 1'b1;
        lk_waddr  = s_r[SIDX_W-1:0];
        lk_wdata  = NIL;
        state_nxt = S_PUSH2;
      end

      S_PUSH2: begin
        if (rtail_r[pp_r] < NIL) begin
          lk_we    = 1'b1;
          lk_waddr = rtail_r[pp_r][SIDX_W-1:0];
          lk_wdata = s_r;
        end else begin
          rhead_nxt[pp_r] = s_r;
        end
        rtail_nxt[pp_r] = s_r;
        if (prom_r) begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_P_STEP;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_D_RD: begin
        rc_raddr  = s_r[SIDX_W-1:0];
        state_nxt = S_D_PRIO;
      end

      S_D_PRIO: begin
        pp_nxt     = prio_idx(rc_rdata.prio);
        cur_nxt    = rhead_r[prio_idx(rc_rdata.prio)];
        prev_nxt   = NIL;
        n_nxt      = '0;
        inwait_nxt = 1'b0;
        state_nxt  = S_U_STEP;
      end

      // Walk the ready queue, then the wait list, looking for s_r
      S_U_STEP: begin
        if (cur_r < NIL && n_r < NIL) begin
          lk_raddr  = cur_r[SIDX_W-1:0];
          state_nxt = S_U_ADV;
        end else if (!inwait_r) begin
          inwait_nxt = 1'b1;
          cur_nxt    = whead_r;
          prev_nxt   = NIL;
          n_nxt      = '0;
        end else begin
          state_nxt = S_FREE;
        end
      end

      S_U_ADV: begin
        if (cur_r == s_r) begin
          if (prev_r < NIL) begin
            lk_we    = 1'b1;
            lk_waddr = prev_r[SIDX_W-1:0];
            lk_wdata = lk_rdata;
          end else if (inwait_r) begin
            whead_nxt = lk_rdata;
          end else begin
            rhead_nxt[pp_r] = lk_rdata;
          end
          if (!inwait_r && rtail_r[pp_r] == s_r) begin
            rtail_nxt[pp_r] = prev_r;
          end
          state_nxt = S_FREE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = lk_rdata;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_U_STEP;
        end
      end

      // Return s_r to the free list
      S_FREE: begin
        in_use_nxt[s_r[SIDX_W-1:0]] = 1'b0;
        lk_we     = 1'b1;
        lk_waddr  = s_r[SIDX_W-1:0];
        lk_wdata  = fhead_r;
        fhead_nxt = s_r;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        if (item_r.command == CMD_COMPLETE) begin
          n_nxt     = '0;
          state_nxt = S_P_STEP;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_Q_RD: begin
        rc_raddr  = s_r[SIDX_W-1:0];
        lk_raddr  = s_r[SIDX_W-1:0];
        state_nxt = S_Q_TAKE;
      end

      // Hand out the task; pop it when nothing was running
      S_Q_TAKE: begin
        res_nxt.result_slot  = 4'(s_r);
        res_nxt.out_handler  = rc_rdata.handler;
        res_nxt.out_event    = rc_rdata.evt;
        res_nxt.out_argument = rc_rdata.argument;
        if (run_r >= NIL) begin
          rhead_nxt[pp_r] = lk_rdata;
          if (lk_rdata >= NIL) begin
            rtail_nxt[pp_r] = NIL;
          end
          lk_we    = 1'b1;
          lk_waddr = s_r[SIDX_W-1:0];
          lk_wdata = NIL;
          run_nxt  = s_r;
        end
        state_nxt = S_DONE;
      end

      S_X_RD: begin
        rc_raddr  = s_r[SIDX_W-1:0];
        state_nxt = S_X_UPD;
      end

      // Stamp the end tick; a repeating task goes on to the wait list, a one-shot one is freed
      S_X_UPD: begin
        nrec          = rc_rdata;
        nrec.last_end = item_r.now_tick;
        rc_we         = 1'b1;
        rc_waddr      = s_r[SIDX_W-1:0];
        rc_wdata      = nrec;
        t_nxt         = item_r.now_tick + rc_rdata.interval;
        if (rc_rdata.rpt) begin
          cur_nxt   = whead_r;
          prev_nxt  = NIL;
          n_nxt     = '0;
          state_nxt = S_W_STEP;
        end else begin
          state_nxt = S_FREE;
        end
      end

      // Find the sorted insertion point in the wait list
      S_W_STEP: begin
        if (cur_r < NIL && n_r < NIL) begin
          rc_raddr  = cur_r[SIDX_W-1:0];
          lk_raddr  = cur_r[SIDX_W-1:0];
          state_nxt = S_W_SUM;
        end else begin
          state_nxt = S_W_LINK;
        end
      end

      S_W_SUM: begin
        nr_nxt    = rc_rdata.last_end + rc_rdata.interval;
        nx_nxt    = lk_rdata;
        state_nxt = S_W_CMP;
      end

      S_W_CMP: begin
        if (tick_before(t_r, nr_r)) begin
          state_nxt = S_W_LINK;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = nx_r;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_W_STEP;
        end
      end

      S_W_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = s_r[SIDX_W-1:0];
        lk_wdata = cur_r;
        if (prev_r < NIL) begin
          state_nxt = S_W_PREV;
        end else begin
          whead_nxt = s_r;
          n_nxt     = '0;
          state_nxt = S_P_STEP;
        end
      end

      S_W_PREV: begin
        lk_we     = 1'b1;
        lk_waddr  = prev_r[SIDX_W-1:0];
        lk_wdata  = s_r;
        n_nxt     = '0;
        state_nxt = S_P_STEP;
      end

      // Move due wait entries to their ready queues
      S_P_STEP: begin
        if (whead_r < NIL && n_r < NIL) begin
          rc_raddr  = whead_r[SIDX_W-1:0];
          lk_raddr  = whead_r[SIDX_W-1:0];
          state_nxt = S_P_SUM;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_P_SUM: begin
        nr_nxt    = rc_rdata.last_end + rc_rdata.interval;
        nx_nxt    = lk_rdata;
        pp_nxt    = prio_idx(rc_rdata.prio);
        s_nxt     = whead_r;
        state_nxt = S_P_CMP;
      end

      S_P_CMP: begin
        if (tick_before(item_r.now_tick, nr_r)) begin
          state_nxt = S_DONE;
        end else begin
          whead_nxt = nx_r;
          prom_nxt  = 1'b1;
          state_nxt = S_PUSH1;
        end
      end

      // Hold the result until the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_use_r    <= '0;
      whead_r     <= NIL;
      fhead_r     <= '0;
      cnt_r       <= '0;
      run_r       <= NIL;
      prom_r      <= 1'b0;
      inwait_r    <= 1'b0;
      for (int p = 0; p < PRIORITY_LEVELS; p++) begin
        rhead_r[p] <= NIL;
        rtail_r[p] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      in_use_r    <= in_use_nxt;
      whead_r     <= whead_nxt;
      fhead_r     <= fhead_nxt;
      cnt_r       <= cnt_nxt;
      run_r       <= run_nxt;
      prom_r      <= prom_nxt;
      inwait_r    <= inwait_nxt;
      rhead_r     <= rhead_nxt;
      rtail_r     <= rtail_nxt;
    end
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    s_r        <= s_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    nx_r       <= nx_nxt;
    n_r        <= n_nxt;
    pp_r       <= pp_nxt;
    nr_r       <= nr_nxt;
    t_r        <= t_nxt;
  end

endmodule

// ===== hdl/tpts_checker.sv =====
// Port-level checks for the timed priority task scheduler, bound to the top.
// Depends on tpts_pkg for the item types and status codes.
module tpts_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input tpts_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input tpts_pkg::out_item_t out_data
);
  import tpts_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Error results carry no slot and no task words
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.result_slot == 4'd0 && out_data.out_handler == 32'd0 &&
      out_data.out_event == 32'd0 && out_data.out_argument == 32'd0)
    else $error("error result carries payload");

  // Status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_NOTHING)
    else $error("undefined status code");

  // No result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind timed_priority_task_scheduler tpts_port_checks u_tpts_port_checks (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
